### rtl/core/rpw_pkg.sv
// Shared types and codes for the response pattern waiter.
// No dependencies.
package rpw_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned TICKS_W = 24;
    localparam int unsigned REQ_W   = 3;
    localparam int unsigned STAT_W  = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 3'd0,
        REQ_RX     = 3'd1,
        REQ_POLL   = 3'd2,
        REQ_TICK   = 3'd3,
        REQ_CANCEL = 3'd4
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_MISSING = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_SUCCESS = 2'd2
    } t_status;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [CHAR_W-1:0]  data_char;
        logic               last_char;
        logic [TICKS_W-1:0] timeout_ticks;
    } t_item;

endpackage

### rtl/core/response_pattern_waiter_core.sv
// Response pattern waiter: input word register, update engine, result register.
// Throughput 1 word per cycle while the output does not stall.
// Pattern match reads one store entry per word from a registered-read RAM.
// Reset (i_rst_n, synchronous, active low) clears all control state and counters;
// pattern store contents are not cleared.
// Depends on rpw_pkg and rpw_engine.
module response_pattern_waiter_core #(
    parameter int unsigned PATTERN_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [rpw_pkg::REQ_W-1:0]     i_req_type,
    input  logic [rpw_pkg::CHAR_W-1:0]    i_data_char,
    input  logic                          i_last_char,
    input  logic [rpw_pkg::TICKS_W-1:0]   i_timeout_ticks,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [rpw_pkg::STAT_W-1:0]    o_status,
    output logic                          o_match_done
);

    logic                         r_s1_valid;
    rpw_pkg::t_item               r_s1;
    logic                         r_out_valid;
    logic [rpw_pkg::STAT_W-1:0]   r_status;
    logic                         r_match_done;
    logic                         s1_adv;
    logic                         in_acc;
    logic [rpw_pkg::STAT_W-1:0]   eng_status;
    logic                         eng_done;

    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_acc  = i_valid && !o_stall;

    rpw_engine #(
        .PATTERN_DEPTH (PATTERN_DEPTH)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (s1_adv),
        .i_item       (r_s1),
        .o_status     (eng_status),
        .o_match_done (eng_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1.req_type      <= i_req_type;
            r_s1.data_char     <= i_data_char;
            r_s1.last_char     <= i_last_char;
            r_s1.timeout_ticks <= i_timeout_ticks;
        end
        if (s1_adv) begin
            r_status     <= eng_status;
            r_match_done <= eng_done;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_match_done = r_match_done;

endmodule

### rtl/core/rpw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/rpw_engine.sv
// Waiter state and per-word update: pattern load, match, poll, tick, cancel.
// Depends on rpw_pkg and rpw_ram.
module rpw_engine #(
    parameter int unsigned PATTERN_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  rpw_pkg::t_item               i_item,
    output logic [rpw_pkg::STAT_W-1:0]   o_status,
    output logic                         o_match_done
);

    localparam int unsigned CW = $clog2(PATTERN_DEPTH + 1);
    localparam int unsigned AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(PATTERN_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [rpw_pkg::TICKS_W-1:0] TICK_ONE_C = {{(rpw_pkg::TICKS_W-1){1'b0}}, 1'b1};

    logic [CW-1:0]               r_load_count,    n_load_count;
    logic [CW-1:0]               r_pattern_length, n_pattern_length;
    logic [CW-1:0]               r_matched_count, n_matched_count;
    logic                        r_response_seen, n_response_seen;
    logic                        r_timer_armed,   n_timer_armed;
    logic [rpw_pkg::TICKS_W-1:0] r_ticks_left,    n_ticks_left;
    logic                        r_byp_valid;
    logic [rpw_pkg::CHAR_W-1:0]  r_byp_data;

    logic                        we;
    logic [AW-1:0]               waddr;
    logic [AW-1:0]               raddr;
    logic [rpw_pkg::CHAR_W-1:0]  rdata;
    logic [rpw_pkg::CHAR_W-1:0]  expected;
    logic [CW-1:0]               load_next;
    logic [CW-1:0]               match_next;
    rpw_pkg::t_status            status;
    logic                        done;

    // read address follows the next matched count so the expected char is ready
    assign raddr = n_matched_count[AW-1:0];

    rpw_ram #(
        .WIDTH (rpw_pkg::CHAR_W),
        .DEPTH (PATTERN_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_item.data_char),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign expected   = r_byp_valid ? r_byp_data : rdata;
    assign load_next  = (r_load_count < DEPTH_C) ? r_load_count + ONE_C : r_load_count;
    assign match_next = r_matched_count + ONE_C;
    assign waddr      = r_load_count[AW-1:0];

    always_comb begin
        n_load_count     = r_load_count;
        n_pattern_length = r_pattern_length;
        n_matched_count  = r_matched_count;
        n_response_seen  = r_response_seen;
        n_timer_armed    = r_timer_armed;
        n_ticks_left     = r_ticks_left;
        we               = 1'b0;
        status           = rpw_pkg::ST_MISSING;
        done             = 1'b0;
        if (i_fire) begin
            case (rpw_pkg::t_req'(i_item.req_type))
                rpw_pkg::REQ_LOAD: begin
                    if (!r_response_seen && r_pattern_length == '0) begin
                        we           = (r_load_count < DEPTH_C);
                        n_load_count = load_next;
                        if (i_item.last_char) begin
                            n_pattern_length = load_next;
                            n_load_count     = '0;
                            n_matched_count  = '0;
                            n_response_seen  = 1'b0;
                            if (i_item.timeout_ticks != '0) begin
                                n_timer_armed = 1'b1;
                                n_ticks_left  = i_item.timeout_ticks;
                            end
                        end
                    end
                end
                rpw_pkg::REQ_RX: begin
                    if (!r_response_seen && r_pattern_length != '0 &&
                        r_matched_count < r_pattern_length &&
                        r_matched_count < DEPTH_C &&
                        expected == i_item.data_char) begin
                        n_matched_count = match_next;
                        if (match_next == r_pattern_length) begin
                            n_response_seen = 1'b1;
                            done            = 1'b1;
                        end
                    end
                end
                rpw_pkg::REQ_POLL: begin
                    if (r_timer_armed && r_ticks_left == '0) begin
                        status = rpw_pkg::ST_TIMEOUT;
                    end else if (r_response_seen) begin
                        status = rpw_pkg::ST_SUCCESS;
                    end
                    if (status != rpw_pkg::ST_MISSING) begin
                        n_load_count     = '0;
                        n_pattern_length = '0;
                        n_matched_count  = '0;
                        n_response_seen  = 1'b0;
                        n_timer_armed    = 1'b0;
                        n_ticks_left     = '0;
                    end
                end
                rpw_pkg::REQ_TICK: begin
                    if (r_timer_armed && r_ticks_left != '0) begin
                        n_ticks_left = r_ticks_left - TICK_ONE_C;
                    end
                end
                rpw_pkg::REQ_CANCEL: begin
                    n_load_count     = '0;
                    n_pattern_length = '0;
                    n_matched_count  = '0;
                    n_response_seen  = 1'b0;
                    n_timer_armed    = 1'b0;
                    n_ticks_left     = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count     <= '0;
            r_pattern_length <= '0;
            r_matched_count  <= '0;
            r_response_seen  <= 1'b0;
            r_timer_armed    <= 1'b0;
            r_ticks_left     <= '0;
            r_byp_valid      <= 1'b0;
        end else begin
            r_load_count     <= n_load_count;
            r_pattern_length <= n_pattern_length;
            r_matched_count  <= n_matched_count;
            r_response_seen  <= n_response_seen;
            r_timer_armed    <= n_timer_armed;
            r_ticks_left     <= n_ticks_left;
            r_byp_valid      <= we && (waddr == raddr);
        end
    end

    // write-to-read forward for the RAM's old-data read
    always_ff @(posedge i_clk) begin
        r_byp_data <= i_item.data_char;
    end

    assign o_status     = status;
    assign o_match_done = done;

endmodule

### tb/response_pattern_waiter_core_tb.sv
// Self-checking testbench for response_pattern_waiter_core: directed table, then random
// pattern/response exchanges under input gaps, output stalls and a long output hold.
// Depends on rpw_pkg and the core RTL; results are checked against an in-bench model or fixed table values.
module response_pattern_waiter_core_tb;

    localparam int DEPTH        = 64;
    localparam int NUM_DIR      = 25;
    localparam int PHASE_WORDS  = 270;
    localparam int PRESS_WORDS  = 80;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [rpw_pkg::REQ_W-1:0] REQ_RSVD5 = 3'd5;
    localparam logic [rpw_pkg::REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [rpw_pkg::REQ_W-1:0] REQ_RSVD7 = 3'd7;

    typedef struct packed {
        logic [rpw_pkg::STAT_W-1:0] status;
        logic                       done;
    } t_answer;

    typedef struct packed {
        rpw_pkg::t_item             w;
        logic                       fixed;
        logic [rpw_pkg::STAT_W-1:0] st;
        logic                       done;
    } t_dir_row;

    logic                         i_clk           = 1'b0;
    logic                         i_rst_n         = 1'b0;
    logic                         i_valid         = 1'b0;
    logic [rpw_pkg::REQ_W-1:0]    i_req_type      = '0;
    logic [rpw_pkg::CHAR_W-1:0]   i_data_char     = '0;
    logic                         i_last_char     = 1'b0;
    logic [rpw_pkg::TICKS_W-1:0]  i_timeout_ticks = '0;
    logic                         i_stall         = 1'b0;
    logic                         o_stall;
    logic                         o_valid;
    logic [rpw_pkg::STAT_W-1:0]   o_status;
    logic                         o_match_done;

    // model state
    logic [rpw_pkg::CHAR_W-1:0]   pat_mem [DEPTH];
    logic [6:0]                   ld_cnt;
    logic [6:0]                   pat_len;
    logic [6:0]                   hit_cnt;
    logic                         resp_seen;
    logic                         tmr_on;
    logic [rpw_pkg::TICKS_W-1:0]  tmr_left;

    t_answer  answer_q [$];
    t_dir_row dir_rows [NUM_DIR];

    int  idle_pct     = 0;
    int  stall_pct    = 0;
    bit  hold_request = 1'b0;
    int  words_sent   = 0;
    int  fail_count   = 0;
    int  cycle_count  = 0;
    int  n_results    = 0;
    int  n_success    = 0;
    int  n_timeout    = 0;
    int  n_done       = 0;

    response_pattern_waiter_core #(
        .PATTERN_DEPTH(DEPTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_data_char     (i_data_char),
        .i_last_char     (i_last_char),
        .i_timeout_ticks (i_timeout_ticks),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_match_done    (o_match_done)
    );

    always #6 i_clk = ~i_clk;

    function automatic void waiter_idle();
        ld_cnt    = '0;
        pat_len   = '0;
        hit_cnt   = '0;
        resp_seen = 1'b0;
        tmr_on    = 1'b0;
        tmr_left  = '0;
    endfunction

    function automatic t_answer waiter_predict(input rpw_pkg::t_item w);
        t_answer a;
        a.status = rpw_pkg::ST_MISSING;
        a.done   = 1'b0;
        case (w.req_type)
            rpw_pkg::REQ_LOAD: begin
                if (!resp_seen && pat_len == 0) begin
                    if (ld_cnt < DEPTH) begin
                        pat_mem[ld_cnt] = w.data_char;
                        ld_cnt = ld_cnt + 7'd1;
                    end
                    if (w.last_char) begin
                        pat_len   = ld_cnt;
                        ld_cnt    = '0;
                        hit_cnt   = '0;
                        resp_seen = 1'b0;
                        if (w.timeout_ticks != 0) begin
                            tmr_on   = 1'b1;
                            tmr_left = w.timeout_ticks;
                        end
                    end
                end
            end
            rpw_pkg::REQ_RX: begin
                if (!resp_seen && pat_len != 0 && hit_cnt < pat_len && hit_cnt < DEPTH) begin
                    if (pat_mem[hit_cnt] == w.data_char) begin
                        hit_cnt = hit_cnt + 7'd1;
                        if (hit_cnt == pat_len) begin
                            resp_seen = 1'b1;
                            a.done    = 1'b1;
                        end
                    end
                end
            end
            rpw_pkg::REQ_POLL: begin
                if (tmr_on && tmr_left == 0) begin
                    waiter_idle();
                    a.status = rpw_pkg::ST_TIMEOUT;
                end else if (resp_seen) begin
                    waiter_idle();
                    a.status = rpw_pkg::ST_SUCCESS;
                end
            end
            rpw_pkg::REQ_TICK: begin
                if (tmr_on && tmr_left != 0) tmr_left = tmr_left - 24'd1;
            end
            rpw_pkg::REQ_CANCEL: waiter_idle();
            default: ;
        endcase
        return a;
    endfunction

    function automatic rpw_pkg::t_item noise_word();
        rpw_pkg::t_item w;
        w.req_type      = 3'($urandom_range(7));
        w.data_char     = 8'($urandom);
        w.last_char     = 1'($urandom);
        w.timeout_ticks = 24'($urandom);
        return w;
    endfunction

    // called and returns at a falling edge
    task automatic send_word(input rpw_pkg::t_item w, input logic fixed,
                             input logic [rpw_pkg::STAT_W-1:0] fx_st, input logic fx_done);
        t_answer a;
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_valid         <= 1'b1;
        i_req_type      <= w.req_type;
        i_data_char     <= w.data_char;
        i_last_char     <= w.last_char;
        i_timeout_ticks <= w.timeout_ticks;
        do @(posedge i_clk); while (o_stall);
        a = waiter_predict(w);
        if (fixed) begin
            a.status = fx_st;
            a.done   = fx_done;
        end
        answer_q.push_back(a);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic run_exchange();
        int                          len;
        int                          steps;
        int                          pick;
        int                          n;
        logic [rpw_pkg::TICKS_W-1:0] tk;
        rpw_pkg::t_item              w;
        pick = $urandom_range(99);
        if (pick < 12) begin
            send_word(noise_word(), 1'b0, rpw_pkg::ST_MISSING, 1'b0);
            return;
        end
        len = ($urandom_range(99) < 6) ? $urandom_range(DEPTH - 4, DEPTH + 6)
                                       : $urandom_range(1, 8);
        case ($urandom_range(5))
            0, 1:    tk = '0;
            2, 3, 4: tk = 24'($urandom_range(1, 12));
            default: tk = 24'($urandom);
        endcase
        for (int i = 0; i < len; i++) begin
            w = noise_word();
            if ($urandom_range(199) == 0) begin
                w.req_type = rpw_pkg::REQ_CANCEL;
                send_word(w, 1'b0, rpw_pkg::ST_MISSING, 1'b0);
            end
            w.req_type  = rpw_pkg::REQ_LOAD;
            w.last_char = (i == len - 1);
            if (w.last_char) w.timeout_ticks = tk;
            send_word(w, 1'b0, rpw_pkg::ST_MISSING, 1'b0);
        end
        steps = 2 * len + 12;
        while (steps > 0 && pat_len != 0 && !resp_seen) begin
            steps--;
            pick = $urandom_range(99);
            w    = noise_word();
            if (pick < 65) begin
                w.req_type  = rpw_pkg::REQ_RX;
                w.data_char = pat_mem[hit_cnt];
            end else if (pick < 80) w.req_type = rpw_pkg::REQ_RX;
            else if (pick < 92)     w.req_type = rpw_pkg::REQ_TICK;
            else if (pick < 97)     w.req_type = rpw_pkg::REQ_POLL;
            else if (pick < 98)     w.req_type = rpw_pkg::REQ_CANCEL;
            else                    w.req_type = rpw_pkg::REQ_LOAD;
            send_word(w, 1'b0, rpw_pkg::ST_MISSING, 1'b0);
        end
        n = $urandom_range(0, 3);
        if (tmr_on && tmr_left < 40 && $urandom_range(2) == 0) n = tmr_left + 1;
        repeat (n) begin
            w = noise_word();
            w.req_type = rpw_pkg::REQ_TICK;
            send_word(w, 1'b0, rpw_pkg::ST_MISSING, 1'b0);
        end
        w = noise_word();
        w.req_type = rpw_pkg::REQ_POLL;
        send_word(w, 1'b0, rpw_pkg::ST_MISSING, 1'b0);
        if ((pat_len != 0 || resp_seen) && $urandom_range(4) != 0) begin
            w = noise_word();
            w.req_type = rpw_pkg::REQ_CANCEL;
            send_word(w, 1'b0, rpw_pkg::ST_MISSING, 1'b0);
        end
    endtask

    // receiver stall generator, with one long hold on request
    initial begin : rx_stall_gen
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= (i_rst_n && $urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_answer a;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (o_status == rpw_pkg::ST_SUCCESS) n_success++;
            if (o_status == rpw_pkg::ST_TIMEOUT) n_timeout++;
            if (o_match_done)                    n_done++;
            if (answer_q.size() == 0) begin
                $error("unexpected result word: status=%0d match_done=%0d",
                       o_status, o_match_done);
                fail_count++;
            end else begin
                a = answer_q.pop_front();
                if (o_status !== a.status) begin
                    $error("status mismatch: expected %0d, actual %0d", a.status, o_status);
                    fail_count++;
                end
                if (o_match_done !== a.done) begin
                    $error("match_done mismatch: expected %0d, actual %0d",
                           a.done, o_match_done);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        dir_rows = '{
            '{'{rpw_pkg::REQ_POLL,   8'h00, 1'b0, 24'h000000}, 1'b1, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_RX,     8'h00, 1'b0, 24'h000000}, 1'b1, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_TICK,   8'h00, 1'b0, 24'hFFFFFF}, 1'b1, rpw_pkg::ST_MISSING, 1'b0},
            '{'{REQ_RSVD5,           8'hFF, 1'b1, 24'hFFFFFF}, 1'b1, rpw_pkg::ST_MISSING, 1'b0},
            '{'{REQ_RSVD6,           8'hFF, 1'b1, 24'hFFFFFF}, 1'b1, rpw_pkg::ST_MISSING, 1'b0},
            '{'{REQ_RSVD7,           8'hFF, 1'b1, 24'hFFFFFF}, 1'b1, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_CANCEL, 8'h00, 1'b0, 24'h000000}, 1'b1, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_LOAD,   8'h4F, 1'b0, 24'h000000}, 1'b0, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_LOAD,   8'h4B, 1'b1, 24'hFFFFFF}, 1'b0, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_LOAD,   8'h11, 1'b1, 24'h000005}, 1'b1, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_RX,     8'h4F, 1'b0, 24'h000000}, 1'b0, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_RX,     8'h00, 1'b0, 24'h000000}, 1'b0, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_POLL,   8'h00, 1'b0, 24'h000000}, 1'b1, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_RX,     8'h4B, 1'b0, 24'h000000}, 1'b0, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_RX,     8'h4B, 1'b0, 24'h000000}, 1'b0, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_POLL,   8'h00, 1'b0, 24'h000000}, 1'b1, rpw_pkg::ST_SUCCESS, 1'b0},
            '{'{rpw_pkg::REQ_LOAD,   8'hFF, 1'b1, 24'h000001}, 1'b0, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_TICK,   8'h00, 1'b0, 24'h000000}, 1'b0, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_TICK,   8'h00, 1'b0, 24'h000000}, 1'b0, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_RX,     8'hFF, 1'b0, 24'h000000}, 1'b0, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_POLL,   8'h00, 1'b0, 24'h000000}, 1'b1, rpw_pkg::ST_TIMEOUT, 1'b0},
            '{'{rpw_pkg::REQ_POLL,   8'h00, 1'b0, 24'h000000}, 1'b1, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_LOAD,   8'h00, 1'b1, 24'h000000}, 1'b0, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_CANCEL, 8'hFF, 1'b1, 24'hFFFFFF}, 1'b0, rpw_pkg::ST_MISSING, 1'b0},
            '{'{rpw_pkg::REQ_POLL,   8'h00, 1'b0, 24'h000000}, 1'b1, rpw_pkg::ST_MISSING, 1'b0}
        };
        waiter_idle();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < NUM_DIR; r++)
            send_word(dir_rows[r].w, dir_rows[r].fixed, dir_rows[r].st, dir_rows[r].done);

        idle_pct = 0;  stall_pct = 0;
        while (words_sent < NUM_DIR + PHASE_WORDS) run_exchange();
        idle_pct = 47; stall_pct = 0;
        while (words_sent < NUM_DIR + 2 * PHASE_WORDS) run_exchange();
        idle_pct = 0;  stall_pct = 47;
        while (words_sent < NUM_DIR + 3 * PHASE_WORDS) run_exchange();
        idle_pct = 12; stall_pct = 12;
        while (words_sent < NUM_DIR + 4 * PHASE_WORDS) run_exchange();

        // long output hold while input keeps pushing
        idle_pct = 0;  stall_pct = 0;
        hold_request = 1'b1;
        while (words_sent < NUM_DIR + 4 * PHASE_WORDS + PRESS_WORDS) run_exchange();

        i_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words: directed table, random exchanges under gaps and stalls, %0s",
                 words_sent, "and one long output hold.");
        $display("Checked %0d results: %0d success, %0d timeout answers, %0d completions.",
                 n_results, n_success, n_timeout, n_done);
        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
